FILE: hw/rtl/hse_pkg.sv
package hse_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic
    {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed
    {
        logic insert;
        logic shift_out;
    } cell_cmd_t;

endpackage

FILE: hw/rtl/hse_cell.sv
module hse_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  hse_pkg::cell_cmd_t                 cmd,
    input  logic signed [hse_pkg::DATA_W-1:0]  new_value,
    input  logic                               left_lt,
    input  logic signed [hse_pkg::DATA_W-1:0]  left_value,
    input  logic                               left_valid,
    input  logic signed [hse_pkg::DATA_W-1:0]  right_value,
    input  logic                               right_valid,
    output logic                               lt,
    output logic signed [hse_pkg::DATA_W-1:0]  value_reg,
    output logic                               valid_reg
);

    logic signed [hse_pkg::DATA_W-1:0] value_next;
    logic                              valid_next;

    // An empty cell acts as plus infinity, so the new element lands in the
    // first cell that is empty or holds a strictly greater value.
    assign lt = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (cmd.insert && lt)
        begin
            if (left_lt)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else if (cmd.shift_out)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else
        begin
            value_next = value_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: hw/rtl/hse_ctrl.sv
module hse_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               is_last,
    input  logic               out_ready,
    input  logic               final_elem,
    output logic               in_ready,
    output logic               out_valid,
    output logic               overflow,
    output hse_pkg::cell_cmd_t cmd
);

    hse_pkg::state_t             state_reg;
    hse_pkg::state_t             state_next;
    logic [hse_pkg::COUNT_W-1:0] count_reg;
    logic [hse_pkg::COUNT_W-1:0] count_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic                        in_xfer;
    logic                        out_xfer;
    logic                        full;

    assign full     = (count_reg == hse_pkg::COUNT_W'(hse_pkg::CAPACITY));
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hse_pkg::ST_LOAD:
            begin
                if (in_xfer && is_last)
                begin
                    state_next = hse_pkg::ST_DRAIN;
                end
            end
            hse_pkg::ST_DRAIN:
            begin
                if (out_xfer && final_elem)
                begin
                    state_next = hse_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = hse_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.insert    = 1'b0;
        cmd.shift_out = 1'b0;
        unique case (state_reg)
            hse_pkg::ST_LOAD:
            begin
                in_ready   = 1'b1;
                cmd.insert = in_valid && !full;
            end
            hse_pkg::ST_DRAIN:
            begin
                out_valid     = 1'b1;
                cmd.shift_out = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // The count restarts as soon as the set closes; the overflow flag must
    // stay until the last result of the set has been transferred.
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (in_xfer)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            if (is_last)
            begin
                count_next = '0;
            end
        end
        if (out_xfer && final_elem)
        begin
            ovf_next = 1'b0;
        end
    end

    assign overflow = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hse_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: hw/rtl/heap_sort_engine_core.sv
// Set sorter built as a chain of insertion cells. Each accepted element is
// placed into the chain in the same cycle, so the next one can be taken at
// once, and up to 64 elements are held; further elements of a set are
// dropped and every result of that set then carries overflow. The element
// marked is_last closes the set, after which the values come out in
// ascending signed order, one per cycle while out_ready is high, from the
// head of the chain; end_of_set marks the greatest. No new element is
// taken until the last result of the set has been transferred. Each cell
// holds one value and has one signed comparator, which sets the clock path.
module heap_sort_engine_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [hse_pkg::DATA_W-1:0]  value,
    input  logic                               is_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [hse_pkg::DATA_W-1:0]  sorted_value,
    output logic                               end_of_set,
    output logic                               overflow
);

    hse_pkg::cell_cmd_t                cmd;
    logic signed [hse_pkg::DATA_W-1:0] cell_value [hse_pkg::CAPACITY];
    logic                              cell_valid [hse_pkg::CAPACITY];
    logic                              cell_lt    [hse_pkg::CAPACITY];

    hse_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .is_last    (is_last),
        .out_ready  (out_ready),
        .final_elem (end_of_set),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .overflow   (overflow),
        .cmd        (cmd)
    );

    for (genvar i = 0; i < hse_pkg::CAPACITY; i++)
    begin : g_cell
        logic                              l_lt;
        logic signed [hse_pkg::DATA_W-1:0] l_value;
        logic                              l_valid;
        logic signed [hse_pkg::DATA_W-1:0] r_value;
        logic                              r_valid;

        if (i == 0)
        begin : g_head
            assign l_lt    = 1'b0;
            assign l_value = value;
            assign l_valid = 1'b0;
        end
        else
        begin : g_body
            assign l_lt    = cell_lt[i-1];
            assign l_value = cell_value[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == hse_pkg::CAPACITY - 1)
        begin : g_tail
            assign r_value = value;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_valid = cell_valid[i+1];
        end

        hse_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .new_value   (value),
            .left_lt     (l_lt),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .right_value (r_value),
            .right_valid (r_valid),
            .lt          (cell_lt[i]),
            .value_reg   (cell_value[i]),
            .valid_reg   (cell_valid[i])
        );
    end

    // The chain is packed from the head, so the head value is the last one
    // when the next cell is empty.
    assign sorted_value = cell_value[0];
    assign end_of_set   = !cell_valid[1];

endmodule
